// ===== rtl/core/kslot_pkg.sv =====
// ----------------------------------------------------------------------------
// kslot_pkg
// Shared types and action codes for the keyed slot registry.
// ----------------------------------------------------------------------------
package kslot_pkg;

  localparam logic [2:0] ACT_RESOLVE = 3'd0;
  localparam logic [2:0] ACT_BEGIN   = 3'd1;
  localparam logic [2:0] ACT_COMMIT  = 3'd2;
  localparam logic [2:0] ACT_MARK    = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] key;
    logic [15:0] ctx_id;
    logic [63:0] seed_data;
  } kslot_in_t;

  typedef struct packed {
    logic [4:0]  slot;
    logic        no_slot;
    logic        conflict;
    logic        write_init;
    logic [63:0] init_value_out;
    logic        released;
    logic        last;
  } kslot_out_t;

endpackage

// ===== rtl/core/kslot_ram.sv =====
// ----------------------------------------------------------------------------
// kslot_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kslot_ram #(
  parameter int Depth = 32,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/kslot_ctrl.sv =====
// ----------------------------------------------------------------------------
// kslot_ctrl
// Sequencer: scans the entry RAM, allocates from the free stack or the fresh
// counter, compacts on commit, and hands result words to the output stage.
// ----------------------------------------------------------------------------
module kslot_ctrl #(
  parameter int MaxSlots = 32,
  parameter int KeyBits  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  kslot_pkg::kslot_in_t  in_word_i,
  output logic                  busy_o,
  input  logic                  out_ok_i,
  output logic                  emit_o,
  output kslot_pkg::kslot_out_t emit_word_o
);
  import kslot_pkg::*;

  localparam int IW = $clog2(MaxSlots);
  localparam int CW = $clog2(MaxSlots + 1);
  localparam int KW = (KeyBits < 32) ? KeyBits : 32;
  localparam int EW = KW + IW + 16;
  localparam logic [CW-1:0] MaxCnt = CW'(MaxSlots);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_EV, ST_POP_RD, ST_POP_EV, ST_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        idx_q, idx_d, wr_q, wr_d;
  logic [CW-1:0]        total_q, total_d, free_q, free_d, fresh_q, fresh_d;
  logic [MaxSlots-1:0]  active_q, active_d, infree_q, infree_d;
  logic [2:0]           act_q, act_d;
  logic [KW-1:0]        key_q, key_d;
  logic [15:0]          ctx_q, ctx_d;
  logic [63:0]          init_q, init_d;

  logic                 e_we, e_re;
  logic [IW-1:0]        e_waddr;
  logic [EW-1:0]        e_wdata, e_rdata;
  logic                 s_we, s_re;
  logic [IW-1:0]        s_waddr, s_raddr;
  logic [IW-1:0]        s_wdata, s_rdata;

  logic [KW-1:0]        rd_key;
  logic [IW-1:0]        rd_slot;
  logic [15:0]          rd_owner;
  logic [IW-1:0]        ci, ti;

  assign {rd_key, rd_slot, rd_owner} = e_rdata;
  assign ci = idx_q[IW-1:0];
  assign ti = total_q[IW-1:0];

  kslot_ram #(.Depth(MaxSlots), .Width(EW)) u_entry_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(ci), .rdata_o(e_rdata)
  );

  kslot_ram #(.Depth(MaxSlots), .Width(IW)) u_free_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    wr_d     = wr_q;
    total_d  = total_q;
    free_d   = free_q;
    fresh_d  = fresh_q;
    active_d = active_q;
    infree_d = infree_q;
    act_d    = act_q;
    key_d    = key_q;
    ctx_d    = ctx_q;
    init_d   = init_q;
    e_we     = 1'b0;
    e_re     = 1'b0;
    e_waddr  = ti;
    e_wdata  = {key_q, IW'(0), ctx_q};
    s_we     = 1'b0;
    s_re     = 1'b0;
    s_waddr  = free_q[IW-1:0];
    s_wdata  = rd_slot;
    s_raddr  = IW'(free_q - 1'b1);
    emit_o   = 1'b0;
    emit_word_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          act_d  = in_word_i.action;
          key_d  = in_word_i.key[KW-1:0];
          ctx_d  = in_word_i.ctx_id;
          init_d = in_word_i.seed_data;
          idx_d  = '0;
          wr_d   = '0;
          case (in_word_i.action)
            ACT_RESOLVE: state_d = ST_SCAN_RD;
            ACT_BEGIN, ACT_COMMIT: begin
              state_d = (in_word_i.ctx_id == 16'd0) ? ST_FINISH : ST_SCAN_RD;
            end
            ACT_MARK: begin
              active_d = '0;
              state_d  = ST_FINISH;
            end
            ACT_CLEAR: begin
              active_d = '0;
              infree_d = '0;
              total_d  = '0;
              free_d   = '0;
              state_d  = ST_FINISH;
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end

      ST_SCAN_RD: begin
        if (idx_q < total_q) begin
          e_re    = 1'b1;
          state_d = ST_SCAN_EV;
        end else if (act_q == ACT_RESOLVE) begin
          if (total_q >= MaxCnt || (free_q == '0 && fresh_q >= MaxCnt)) begin
            if (out_ok_i) begin
              emit_o              = 1'b1;
              emit_word_o.no_slot = 1'b1;
              emit_word_o.last    = 1'b1;
              state_d             = ST_IDLE;
            end
          end else if (free_q != '0) begin
            state_d = ST_POP_RD;
          end else if (out_ok_i) begin
            e_we                       = 1'b1;
            e_wdata                    = {key_q, fresh_q[IW-1:0], ctx_q};
            active_d[ti]               = 1'b1;
            total_d                    = total_q + 1'b1;
            fresh_d                    = fresh_q + 1'b1;
            emit_o                     = 1'b1;
            emit_word_o.slot           = 5'(fresh_q[IW-1:0]);
            emit_word_o.write_init     = 1'b1;
            emit_word_o.init_value_out = init_q;
            emit_word_o.last           = 1'b1;
            state_d                    = ST_IDLE;
          end
        end else begin
          if (act_q == ACT_COMMIT) begin
            total_d = wr_q;
          end
          state_d = ST_FINISH;
        end
      end

      ST_SCAN_EV: begin
        case (act_q)
          ACT_RESOLVE: begin
            if (rd_key == key_q) begin
              if (out_ok_i) begin
                emit_o           = 1'b1;
                emit_word_o.last = 1'b1;
                state_d          = ST_IDLE;
                if (ctx_q != 16'd0 && rd_owner != 16'd0 && rd_owner != ctx_q) begin
                  emit_word_o.no_slot  = 1'b1;
                  emit_word_o.conflict = 1'b1;
                end else begin
                  if (rd_owner == 16'd0) begin
                    e_we    = 1'b1;
                    e_waddr = ci;
                    e_wdata = {rd_key, rd_slot, ctx_q};
                  end
                  active_d[ci]     = 1'b1;
                  emit_word_o.slot = 5'(rd_slot);
                end
              end
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_SCAN_RD;
            end
          end
          ACT_BEGIN: begin
            if (rd_owner == ctx_q) begin
              active_d[ci] = 1'b0;
            end
            idx_d   = idx_q + 1'b1;
            state_d = ST_SCAN_RD;
          end
          ACT_COMMIT: begin
            if (rd_owner == ctx_q && !active_q[ci]) begin
              if (out_ok_i) begin
                emit_o               = 1'b1;
                emit_word_o.slot     = 5'(rd_slot);
                emit_word_o.released = 1'b1;
                if (!infree_q[rd_slot] && free_q < MaxCnt) begin
                  s_we              = 1'b1;
                  free_d            = free_q + 1'b1;
                  infree_d[rd_slot] = 1'b1;
                end
                idx_d   = idx_q + 1'b1;
                state_d = ST_SCAN_RD;
              end
            end else begin
              if (wr_q != idx_q) begin
                e_we                     = 1'b1;
                e_waddr                  = wr_q[IW-1:0];
                e_wdata                  = e_rdata;
                active_d[wr_q[IW-1:0]]   = active_q[ci];
              end
              wr_d    = wr_q + 1'b1;
              idx_d   = idx_q + 1'b1;
              state_d = ST_SCAN_RD;
            end
          end
          default: state_d = ST_FINISH;
        endcase
      end

      ST_POP_RD: begin
        s_re    = 1'b1;
        state_d = ST_POP_EV;
      end

      ST_POP_EV: begin
        if (out_ok_i) begin
          free_d                     = free_q - 1'b1;
          infree_d[s_rdata]          = 1'b0;
          e_we                       = 1'b1;
          e_wdata                    = {key_q, s_rdata, ctx_q};
          active_d[ti]               = 1'b1;
          total_d                    = total_q + 1'b1;
          emit_o                     = 1'b1;
          emit_word_o.slot           = 5'(s_rdata);
          emit_word_o.write_init     = 1'b1;
          emit_word_o.init_value_out = init_q;
          emit_word_o.last           = 1'b1;
          state_d                    = ST_IDLE;
        end
      end

      ST_FINISH: begin
        if (out_ok_i) begin
          emit_o           = 1'b1;
          emit_word_o.last = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      wr_q     <= '0;
      total_q  <= '0;
      free_q   <= '0;
      fresh_q  <= '0;
      active_q <= '0;
      infree_q <= '0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      wr_q     <= wr_d;
      total_q  <= total_d;
      free_q   <= free_d;
      fresh_q  <= fresh_d;
      active_q <= active_d;
      infree_q <= infree_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    key_q  <= key_d;
    ctx_q  <= ctx_d;
    init_q <= init_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MaxCnt) else $error("entry count overflow");
  a_free_members: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(infree_q) == int'(free_q)) else $error("free set out of sync");
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q <= idx_q) else $error("compaction write passed read");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && emit_word_o.last |=> state_q == ST_IDLE) else $error("last without idle");
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= MaxCnt) else $error("fresh counter overflow");

endmodule

// ===== rtl/core/keyed_slot_registry.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_registry
// Key to slot registry with owner contexts, active marks and a free stack.
// Flow: mark-all, clear and unknown actions go straight to the last word; begin
//   and commit with a nonzero context scan every entry; resolve scans to a key hit,
//   or all entries on a miss and then allocates if room (popping the free stack first).
// Throughput: one item at a time; the RAM scan reads, then evaluates each entry.
// Reset: table, free stack and fresh counter empty; no clearing pass.
// ----------------------------------------------------------------------------
module keyed_slot_registry #(
  parameter int MAX_SLOTS = 32,
  parameter int KEY_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  kslot_pkg::kslot_in_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output kslot_pkg::kslot_out_t out_word_o
);
  import kslot_pkg::*;

  logic       busy, emit, out_ok, out_valid_q;
  kslot_out_t emit_word, out_word_q;

  assign in_stall_o = busy;
  assign out_ok     = !out_valid_q || !out_stall_i;

  kslot_ctrl #(.MaxSlots(MAX_SLOTS), .KeyBits(KEY_BITS)) u_ctrl (
    .clk_i, .rst_ni,
    .accept_i(in_valid_i && !busy),
    .in_word_i,
    .busy_o(busy),
    .out_ok_i(out_ok),
    .emit_o(emit),
    .emit_word_o(emit_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ok) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ok && emit) begin
      out_word_q <= emit_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
